// ===== hdl/bthr_pkg.sv =====
package bthr_pkg;

    // Input beat layout.
    localparam int ELAPSED_W  = 20;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 16;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_QUICK_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DELAY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_STEP  = 2'd2;

    localparam logic [CFG_W-1:0] QUICK_WINDOW_RST = 32'd250000;
    localparam logic [CFG_W-1:0] REPEAT_DELAY_RST = 32'd500000;
    localparam logic [CFG_W-1:0] REPEAT_STEP_RST  = 32'd100000;

    // Flags carried from one tick to the next.
    typedef struct packed {
        logic press_history;
        logic release_history;
        logic hold_armed;
    } hist_t;

    // Result flags; declared last-first so short_press sits in bit 0.
    typedef struct packed {
        logic hold_start;
        logic held_long;
        logic auto_repeat;
        logic double_release;
        logic confirmed_release;
        logic short_release;
        logic double_press;
        logic confirmed_press;
        logic short_press;
    } result_t;

    // Settings presented to the tick logic.
    typedef struct packed {
        logic [CFG_W-1:0] quick_window;
        logic [CFG_W-1:0] repeat_delay;
        logic [CFG_W-1:0] repeat_step;
    } cfg_t;

endpackage

// ===== hdl/bthr_tick.sv =====
module bthr_tick
    import bthr_pkg::*;
#(
    parameter int TIMER_BITS = 32
) (
    input  cfg_t                  cfg,
    input  logic [ELAPSED_W-1:0]  elapsed_us,
    input  logic                  was_down,
    input  logic                  is_down,
    input  logic [TIMER_BITS-1:0] since_release,
    input  logic [TIMER_BITS-1:0] since_press,
    input  logic [TIMER_BITS-1:0] hold_time,
    input  logic [TIMER_BITS-1:0] repeat_acc,
    input  hist_t                 hist,
    output logic [TIMER_BITS-1:0] since_release_next,
    output logic [TIMER_BITS-1:0] since_press_next,
    output logic [TIMER_BITS-1:0] hold_time_next,
    output logic [TIMER_BITS-1:0] repeat_acc_next,
    output hist_t                 hist_next,
    output result_t               result
);

    localparam int SUM_W = ((TIMER_BITS > ELAPSED_W) ? TIMER_BITS : ELAPSED_W) + 1;
    localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

    logic [TIMER_BITS-1:0] srt_add;
    logic [TIMER_BITS-1:0] spt_add;
    logic [TIMER_BITS-1:0] ht_add;
    logic [TIMER_BITS-1:0] acc_add;
    logic [CMP_W-1:0]      qw_x;
    logic [CMP_W-1:0]      delay_x;
    logic [CMP_W-1:0]      step_x;
    logic [CMP_W-1:0]      acc_x;

    // Add the tick time, pinning at all ones on overflow.
    function automatic logic [TIMER_BITS-1:0] sat_add(
        input logic [TIMER_BITS-1:0] a,
        input logic [ELAPSED_W-1:0]  e
    );
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(a) + SUM_W'(e);
        if (sum[SUM_W-1:TIMER_BITS] != '0) begin
            return '1;
        end
        return sum[TIMER_BITS-1:0];
    endfunction

    assign srt_add = sat_add(since_release, elapsed_us);
    assign spt_add = sat_add(since_press, elapsed_us);
    assign ht_add  = sat_add(hold_time, elapsed_us);
    assign acc_add = sat_add(repeat_acc, elapsed_us);
    assign qw_x    = CMP_W'(cfg.quick_window);
    assign delay_x = CMP_W'(cfg.repeat_delay);
    assign step_x  = CMP_W'(cfg.repeat_step);
    assign acc_x   = CMP_W'(acc_add);

    always_comb begin
        since_release_next = srt_add;
        since_press_next   = spt_add;
        hold_time_next     = '0;
        repeat_acc_next    = '0;
        hist_next          = hist;
        result             = '0;

        // Either gap running past the window ends any tap sequence.
        if ((CMP_W'(srt_add) > qw_x) || (CMP_W'(spt_add) > qw_x)) begin
            hist_next.press_history   = 1'b0;
            hist_next.release_history = 1'b0;
        end

        if (is_down) begin
            hold_time_next  = ht_add;
            repeat_acc_next = acc_add;
            if (!was_down) begin
                hist_next.hold_armed = 1'b1;
                result.double_press  = hist_next.press_history;
                if (CMP_W'(srt_add) < qw_x) begin
                    result.short_press      = 1'b1;
                    hist_next.press_history = 1'b1;
                end
                since_press_next = '0;
            end else if (acc_x > delay_x) begin
                result.auto_repeat = 1'b1;
                if (step_x >= acc_x) begin
                    repeat_acc_next = '0;
                end else begin
                    repeat_acc_next = TIMER_BITS'(acc_x - step_x);
                end
            end
            if (CMP_W'(ht_add) >= qw_x) begin
                result.held_long = 1'b1;
                if (hist_next.hold_armed) begin
                    result.hold_start    = 1'b1;
                    hist_next.hold_armed = 1'b0;
                end
            end
        end else begin
            hist_next.hold_armed = 1'b0;
            if (was_down) begin
                result.double_release = hist_next.release_history;
                if (CMP_W'(spt_add) < qw_x) begin
                    result.short_release      = 1'b1;
                    hist_next.release_history = 1'b1;
                end
                since_release_next = '0;
            end
        end

        result.confirmed_press   = result.short_press & ~result.double_press;
        result.confirmed_release = result.short_release & ~result.double_release;
    end

endmodule

// ===== hdl/button_tap_hold_repeat_detector_unit.sv =====
// Button tap, double-tap, hold and auto-repeat detector.
//
// Each slave beat is one sample tick: the time since the previous tick and
// the button level on the previous and current sample. Every tick yields
// exactly one master beat carrying nine event flags (presses, releases,
// double events, auto-repeat, long hold and the first tick of a long hold).
// The three timing settings are written through the cfg_* channel, which
// is always ready; they should only change while no tick is in flight.
//
// A beat taken on the slave side lands in an input register; once the
// result register is free or being emptied, the tick logic updates the
// timers and history flags and loads the result register, raising m_tvalid.
// One tick per cycle is sustained while m_tready stays high: the only loop
// is the update of the timer and flag registers.
//
// Reset clears all timers and flags, empties both stages and restores the
// default settings. When the master side stalls, the result register holds
// and the input register fills; s_tready falls only once both are full.
module button_tap_hold_repeat_detector_unit
    import bthr_pkg::*;
#(
    parameter int TIMER_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // Bits from 0: elapsed_us[19:0], was_down, is_down, two zero pad bits.
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // Bits from 0: short_press, confirmed_press, double_press, short_release,
    // confirmed_release, double_release, auto_repeat, held_long, hold_start,
    // then seven zero pad bits.
    output logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    cfg_t                  cfg_reg;
    logic                  in_valid_reg;
    logic [ELAPSED_W-1:0]  elapsed_reg;
    logic                  was_down_reg;
    logic                  is_down_reg;
    logic                  out_valid_reg;
    result_t               result_reg;
    logic [TIMER_BITS-1:0] since_release_reg;
    logic [TIMER_BITS-1:0] since_press_reg;
    logic [TIMER_BITS-1:0] hold_time_reg;
    logic [TIMER_BITS-1:0] repeat_acc_reg;
    hist_t                 hist_reg;

    logic [TIMER_BITS-1:0] since_release_next;
    logic [TIMER_BITS-1:0] since_press_next;
    logic [TIMER_BITS-1:0] hold_time_next;
    logic [TIMER_BITS-1:0] repeat_acc_next;
    hist_t                 hist_next;
    result_t               result_next;
    logic                  advance;

    // The tick in the input register moves on when the result slot is free
    // or is being emptied in this cycle.
    assign advance   = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready  = ~in_valid_reg | advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = M_TDATA_W'(result_reg);
    assign cfg_ready = 1'b1;

    bthr_tick #(
        .TIMER_BITS(TIMER_BITS)
    ) u_tick (
        .cfg               (cfg_reg),
        .elapsed_us        (elapsed_reg),
        .was_down          (was_down_reg),
        .is_down           (is_down_reg),
        .since_release     (since_release_reg),
        .since_press       (since_press_reg),
        .hold_time         (hold_time_reg),
        .repeat_acc        (repeat_acc_reg),
        .hist              (hist_reg),
        .since_release_next(since_release_next),
        .since_press_next  (since_press_next),
        .hold_time_next    (hold_time_next),
        .repeat_acc_next   (repeat_acc_next),
        .hist_next         (hist_next),
        .result            (result_next)
    );

    // Settings. An index outside the register list is dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.quick_window <= QUICK_WINDOW_RST;
            cfg_reg.repeat_delay <= REPEAT_DELAY_RST;
            cfg_reg.repeat_step  <= REPEAT_STEP_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_QUICK_WINDOW: cfg_reg.quick_window <= cfg_data;
                CFG_REPEAT_DELAY: cfg_reg.repeat_delay <= cfg_data;
                CFG_REPEAT_STEP:  cfg_reg.repeat_step  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            elapsed_reg  <= s_tdata[ELAPSED_W-1:0];
            was_down_reg <= s_tdata[ELAPSED_W];
            is_down_reg  <= s_tdata[ELAPSED_W+1];
        end
    end

    // Tick state and the result stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg     <= 1'b0;
            since_release_reg <= '0;
            since_press_reg   <= '0;
            hold_time_reg     <= '0;
            repeat_acc_reg    <= '0;
            hist_reg          <= '0;
        end else begin
            if (advance) begin
                out_valid_reg     <= 1'b1;
                since_release_reg <= since_release_next;
                since_press_reg   <= since_press_next;
                hold_time_reg     <= hold_time_next;
                repeat_acc_reg    <= repeat_acc_next;
                hist_reg          <= hist_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    // A hold start is always also a long hold.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && result_reg.hold_start) |-> result_reg.held_long)
        else $error("hold_start without held_long");

    // A press edge never comes with a release edge or an auto-repeat from the same tick.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (result_reg.short_press || result_reg.double_press))
            |-> !(result_reg.short_release || result_reg.double_release
                  || result_reg.auto_repeat))
        else $error("press and release events in one tick");

    // The hold is never armed while the button reads released.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !is_down_reg) |=> !hist_reg.hold_armed)
        else $error("hold armed after release");

    // After reset both stages are empty.
    assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && !in_valid_reg))
        else $error("pipeline not empty after reset");

endmodule

// ===== tb/tb_button_tap_hold_repeat_detector_unit.sv =====
`timescale 1ns / 1ps

module tb_button_tap_hold_repeat_detector_unit;
    import bthr_pkg::*;

    // Index that no register answers to; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam logic [19:0] ELAPSED_MAX = 20'hFFFFF;
    localparam logic [31:0] REG_MAX     = 32'hFFFF_FFFF;

    // Event masks, bit positions as on m_tdata.
    localparam logic [8:0] NO_FLAGS = 9'h000;
    localparam logic [8:0] F_QP     = 9'h001;
    localparam logic [8:0] F_CP     = 9'h002;
    localparam logic [8:0] F_DP     = 9'h004;
    localparam logic [8:0] F_QR     = 9'h008;
    localparam logic [8:0] F_CR     = 9'h010;
    localparam logic [8:0] F_DR     = 9'h020;
    localparam logic [8:0] F_AR     = 9'h040;
    localparam logic [8:0] F_HL     = 9'h080;
    localparam logic [8:0] F_HS     = 9'h100;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    // Bits from 0: elapsed_us[19:0], was_down, is_down, two zero pad bits.
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    // Bits from 0: short_press, confirmed_press, double_press, short_release,
    // confirmed_release, double_release, auto_repeat, held_long, hold_start.
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    button_tap_hold_repeat_detector_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // The run is cut off here if the result stream ever stops.
    initial begin
        #400000;
        $display("RESULT: ERROR");
        $finish;
    end

    // -------------------------------------------------------------------------
    // Predictor: its own copy of the settings, timers and history flags.
    // -------------------------------------------------------------------------
    logic [31:0] win       = QUICK_WINDOW_RST;
    logic [31:0] rep_delay = REPEAT_DELAY_RST;
    logic [31:0] rep_step  = REPEAT_STEP_RST;

    logic [31:0] t_since_rel = '0;
    logic [31:0] t_since_prs = '0;
    logic [31:0] t_hold      = '0;
    logic [31:0] t_rep       = '0;
    logic        h_press     = 1'b0;
    logic        h_release   = 1'b0;
    logic        h_armed     = 1'b0;

    // Timers stick at all ones instead of wrapping.
    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [19:0] e);
        logic [32:0] sum;
        sum = {1'b0, a} + {13'd0, e};
        return sum[32] ? REG_MAX : sum[31:0];
    endfunction

    // One tick through the detector; updates the state and returns the flags.
    function automatic result_t advance_button(input logic [19:0] dt, input logic was,
                                               input logic now);
        result_t r;
        r = '0;
        t_since_rel = sat_add(t_since_rel, dt);
        t_since_prs = sat_add(t_since_prs, dt);
        // Too long since either edge: any pending double is forgotten.
        if (t_since_rel > win || t_since_prs > win) begin
            h_press   = 1'b0;
            h_release = 1'b0;
        end
        if (now) begin
            t_hold = sat_add(t_hold, dt);
            t_rep  = sat_add(t_rep, dt);
            if (!was) begin
                // Press edge. The hold timer is left alone here, so a press
                // with no release in between keeps counting on.
                h_armed = 1'b1;
                r.double_press = h_press;
                if (t_since_rel < win) begin
                    r.short_press = 1'b1;
                    h_press = 1'b1;
                end
                t_since_prs = '0;
            end else if (t_rep > rep_delay) begin
                r.auto_repeat = 1'b1;
                t_rep = (rep_step >= t_rep) ? '0 : t_rep - rep_step;
            end
            if (t_hold >= win) begin
                r.held_long = 1'b1;
                if (h_armed) begin
                    r.hold_start = 1'b1;
                    h_armed = 1'b0;
                end
            end
        end else begin
            t_hold  = '0;
            t_rep   = '0;
            h_armed = 1'b0;
            if (was) begin
                r.double_release = h_release;
                if (t_since_prs < win) begin
                    r.short_release = 1'b1;
                    h_release = 1'b1;
                end
                t_since_rel = '0;
            end
        end
        r.confirmed_press   = r.short_press & ~r.double_press;
        r.confirmed_release = r.short_release & ~r.double_release;
        return r;
    endfunction

    // -------------------------------------------------------------------------
    // Beat monitor and result checker.
    // -------------------------------------------------------------------------
    result_t flags_due [$];
    int      faults = 0;

    // A directed row may carry a flag set typed in by hand; it travels
    // alongside the beat so the monitor knows which expectation to queue.
    logic       tick_typed = 1'b0;
    logic [8:0] tick_flags = '0;

    string flag_name [9] = '{"short_press", "confirmed_press", "double_press",
                             "short_release", "confirmed_release", "double_release",
                             "auto_repeat", "held_long", "hold_start"};

    task automatic flag_error(input string msg);
        faults++;
        $display("%0t ns: %s", $time, msg);
    endtask

    result_t    modeled;
    logic [8:0] want;
    logic [8:0] got;

    // All handshakes are sampled in the active region of the rising edge,
    // where every signal still holds its value from before the edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_QUICK_WINDOW: win       = cfg_data;
                    CFG_REPEAT_DELAY: rep_delay = cfg_data;
                    CFG_REPEAT_STEP:  rep_step  = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                modeled = advance_button(s_tdata[19:0], s_tdata[20], s_tdata[21]);
                flags_due.push_back(tick_typed ? result_t'(tick_flags) : modeled);
            end
            if (m_tvalid && m_tready) begin
                if (flags_due.size() == 0) begin
                    flag_error($sformatf("result beat %h with nothing outstanding",
                                         m_tdata));
                end else begin
                    want = flags_due.pop_front();
                    got  = m_tdata[8:0];
                    for (int k = 0; k < 9; k++) begin
                        if (got[k] !== want[k])
                            flag_error($sformatf("%s is %b, should be %b",
                                                 flag_name[k], got[k], want[k]));
                    end
                end
            end
        end
    end

    // -------------------------------------------------------------------------
    // Stimulus.
    // -------------------------------------------------------------------------

    // While steady is set, neither side inserts idle cycles.
    logic steady = 1'b0;

    always @(posedge aclk)
        m_tready <= steady || ($urandom_range(0, 99) >= 6);

    typedef struct packed {
        logic [19:0] dt;
        logic        was;
        logic        now;
        logic        typed;
        logic [8:0]  flags;
    } tick_row_t;

    // Directed ticks under the reset settings (window 250000, delay 500000,
    // step 100000). Rows with typed = 0 are checked against the predictor.
    tick_row_t script [20] = '{
        '{20'd0,       1'b0, 1'b0, 1'b1, NO_FLAGS},    // idle after reset
        '{20'd1000,    1'b0, 1'b1, 1'b1, F_QP | F_CP}, // first quick tap
        '{20'd1000,    1'b1, 1'b0, 1'b1, F_QR | F_CR},
        '{20'd1000,    1'b0, 1'b1, 1'b1, F_QP | F_DP}, // second tap: double
        '{20'd1000,    1'b1, 1'b0, 1'b1, F_QR | F_DR},
        '{ELAPSED_MAX, 1'b0, 1'b1, 1'b1, F_HL | F_HS}, // slow press, long hold
        '{20'd0,       1'b1, 1'b1, 1'b1, F_AR | F_HL}, // accumulator past delay
        '{20'd0,       1'b1, 1'b1, 1'b0, NO_FLAGS},
        '{20'd0,       1'b0, 1'b1, 1'b0, NO_FLAGS},    // press edge while held
        '{20'd200000,  1'b1, 1'b1, 1'b0, NO_FLAGS},
        '{ELAPSED_MAX, 1'b1, 1'b0, 1'b0, NO_FLAGS},
        '{20'd250000,  1'b0, 1'b1, 1'b0, NO_FLAGS},    // exactly on the window
        '{20'd249999,  1'b1, 1'b0, 1'b0, NO_FLAGS},    // just inside it
        '{20'd249999,  1'b0, 1'b1, 1'b0, NO_FLAGS},
        '{20'd1,       1'b1, 1'b1, 1'b0, NO_FLAGS},    // hold reaches the window
        '{20'd0,       1'b0, 1'b0, 1'b0, NO_FLAGS},
        '{20'd0,       1'b1, 1'b1, 1'b0, NO_FLAGS},    // levels that disagree
        '{ELAPSED_MAX, 1'b1, 1'b1, 1'b0, NO_FLAGS},
        '{20'd500000,  1'b1, 1'b1, 1'b0, NO_FLAGS},
        '{20'd0,       1'b1, 1'b0, 1'b0, NO_FLAGS}
    };

    logic btn_level = 1'b0;

    // Offers one tick beat and returns at the edge where it is taken. The
    // valid line is lowered only when an idle gap actually follows.
    task automatic send_tick(input logic [19:0] dt, input logic was, input logic now,
                             input logic typed, input logic [8:0] flags);
        int gap;
        gap = 0;
        while (!steady && $urandom_range(0, 99) < 6)
            gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= {2'b00, now, was, dt};
        tick_typed <= typed;
        tick_flags <= flags;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stops offering beats and waits until every queued result has come back.
    // The first edge lets the monitor queue the beat taken just now.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (flags_due.size() != 0)
            @(posedge aclk);
    endtask

    // Writes all three settings in back-to-back beats, plus one beat to the
    // unused index with random data, which the block must ignore.
    task automatic write_settings(input logic [31:0] qw, input logic [31:0] rd,
                                  input logic [31:0] rs);
        logic [CFG_IDX_W-1:0] idx [4];
        logic [CFG_W-1:0]     val [4];
        idx = '{CFG_QUICK_WINDOW, CFG_UNUSED, CFG_REPEAT_DELAY, CFG_REPEAT_STEP};
        val = '{qw, $urandom(), rd, rs};
        cfg_valid <= 1'b1;
        for (int k = 0; k < 4; k++) begin
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    // Elapsed times are mostly small against the window so taps and doubles
    // happen, with zero, the maximum and full-range values mixed in.
    function automatic logic [19:0] pick_elapsed();
        int          pick;
        logic [31:0] lim;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            return '0;
        if (pick < 10)
            return ELAPSED_MAX;
        lim = (pick < 60) ? win / 8 : win / 2;
        if (lim > 32'(ELAPSED_MAX))
            lim = 32'(ELAPSED_MAX);
        if (pick < 80)
            return 20'($urandom_range(0, lim));
        return 20'($urandom());
    endfunction

    // Mostly a consistent level sequence (previous level = last current
    // level), with presses held longer than releases so repeats build up;
    // a few beats carry levels that disagree.
    task automatic random_ticks(input int n);
        logic nxt;
        logic was;
        for (int k = 0; k < n; k++) begin
            nxt = ($urandom_range(0, 99) < (btn_level ? 12 : 35)) ? ~btn_level : btn_level;
            was = btn_level;
            if ($urandom_range(0, 99) < 8) begin
                was = 1'($urandom_range(0, 1));
                nxt = 1'($urandom_range(0, 1));
            end
            send_tick(pick_elapsed(), was, nxt, 1'b0, NO_FLAGS);
            btn_level = nxt;
        end
    endtask

    logic [31:0] qw_pick;

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (script[i])
            send_tick(script[i].dt, script[i].was, script[i].now,
                      script[i].typed, script[i].flags);
        drain();
        btn_level = 1'b0;

        for (int p = 0; p < 8; p++) begin
            steady = (p == 4);
            case (p)
                0: write_settings('0, '0, '0);
                1: write_settings(REG_MAX, REG_MAX, REG_MAX);
                2: write_settings(QUICK_WINDOW_RST, REPEAT_DELAY_RST, REPEAT_STEP_RST);
                // A step larger than anything the accumulator holds.
                3: write_settings($urandom_range(1000, 600000),
                                  $urandom_range(0, 800000), REG_MAX);
                4: write_settings($urandom(), $urandom(), $urandom());
                5: begin
                    qw_pick = $urandom_range(50000, 400000);
                    write_settings(qw_pick, $urandom_range(0, qw_pick),
                                   $urandom_range(0, qw_pick / 2));
                end
                6: write_settings(32'(ELAPSED_MAX), 32'd1, 32'd1);
                default: write_settings($urandom_range(20000, 300000),
                                        $urandom_range(0, 1000000),
                                        $urandom_range(0, 200000));
            endcase
            random_ticks(135);
            drain();
        end

        // One long hold at the largest elapsed time. Once the accumulator
        // passes the delay, the zero step lets a repeat fire on every tick.
        steady = 1'b1;
        write_settings(REG_MAX, 32'd20000000, '0);
        send_tick(ELAPSED_MAX, 1'b0, 1'b1, 1'b0, NO_FLAGS);
        for (int k = 0; k < 40; k++)
            send_tick(ELAPSED_MAX, 1'b1, 1'b1, 1'b0, NO_FLAGS);
        send_tick(ELAPSED_MAX, 1'b1, 1'b0, 1'b0, NO_FLAGS);
        send_tick(20'd0, 1'b0, 1'b1, 1'b0, NO_FLAGS);
        send_tick(20'd0, 1'b1, 1'b0, 1'b0, NO_FLAGS);
        drain();
        steady = 1'b0;

        // Let any stray result beat show up before the verdict.
        repeat (10) @(posedge aclk);
        if (faults == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
